### hw/rtl/wsfp_pkg.sv
package wsfp_pkg;

  localparam int SigW = 24;
  localparam int LenW = 12;
  localparam int S1gLenW = 9;
  localparam int SymW = 11;
  localparam int EncW = 3;
  localparam int McsW = 4;
  localparam int NumW = 16;
  localparam int BiasW = 8;
  localparam int ShiftW = 3;
  localparam int RecipW = 23;
  localparam int RecipShift = 22;
  localparam int ProdW = NumW + RecipW;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusFirst  = 2'd1,
    StatusParity = 2'd2,
    StatusRate   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ModBpsk  = 2'd0,
    ModQpsk  = 2'd1,
    Mod16qam = 2'd2,
    Mod64qam = 2'd3
  } mod_e;

  localparam logic [3:0] Rate6M  = 4'hB;
  localparam logic [3:0] Rate9M  = 4'hF;
  localparam logic [3:0] Rate12M = 4'hA;
  localparam logic [3:0] Rate18M = 4'hE;
  localparam logic [3:0] Rate24M = 4'h9;
  localparam logic [3:0] Rate36M = 4'hD;
  localparam logic [3:0] Rate48M = 4'h8;
  localparam logic [3:0] Rate54M = 4'hC;

  localparam logic [McsW-1:0] Mcs0 = 4'd0;
  localparam logic [McsW-1:0] Mcs1 = 4'd1;
  localparam logic [McsW-1:0] Mcs2 = 4'd2;

  localparam logic [NumW-1:0] LegacyOverhead = 16'd22;
  localparam logic [NumW-1:0] S1gOverhead = 16'd14;

  // ceil(n / d) with d = 2^shift * c: add d-1, shift, multiply by ceil(2^22 / c)
  typedef struct packed {
    logic [BiasW-1:0]  bias;
    logic [ShiftW-1:0] shift;
    logic [RecipW-1:0] recip;
  } div_t;

  typedef struct packed {
    status_e           status;
    logic              upd;
    logic              mcs_we;
    logic [McsW-1:0]   mcs;
    logic [EncW-1:0]   enc;
    mod_e              modulation;
    logic [LenW-1:0]   bytes;
  } dec_t;

  function automatic div_t legacy_div(input logic [EncW-1:0] enc);
    div_t d;
    case (enc)
      3'd0:    d = '{bias: 8'd23,  shift: 3'd3, recip: 23'd1398102};
      3'd1:    d = '{bias: 8'd35,  shift: 3'd2, recip: 23'd466034};
      3'd2:    d = '{bias: 8'd47,  shift: 3'd4, recip: 23'd1398102};
      3'd3:    d = '{bias: 8'd71,  shift: 3'd3, recip: 23'd466034};
      3'd4:    d = '{bias: 8'd95,  shift: 3'd5, recip: 23'd1398102};
      3'd5:    d = '{bias: 8'd143, shift: 3'd4, recip: 23'd466034};
      3'd6:    d = '{bias: 8'd191, shift: 3'd6, recip: 23'd1398102};
      default: d = '{bias: 8'd215, shift: 3'd3, recip: 23'd155345};
    endcase
    return d;
  endfunction

endpackage

### hw/rtl/wsfp_symdiv.sv
module wsfp_symdiv (
  input  logic [wsfp_pkg::NumW-1:0] num_i,
  input  wsfp_pkg::div_t            div_i,
  output logic [wsfp_pkg::SymW-1:0] sym_o
);
  import wsfp_pkg::*;

  logic [NumW-1:0]  biased;
  logic [NumW-1:0]  scaled;
  logic [ProdW-1:0] prod;

  assign biased = num_i + {{(NumW-BiasW){1'b0}}, div_i.bias};
  assign scaled = biased >> div_i.shift;
  assign prod   = {{RecipW{1'b0}}, scaled} * {{NumW{1'b0}}, div_i.recip};
  assign sym_o  = prod[RecipShift +: SymW];

endmodule

### hw/rtl/wsfp_decode.sv
module wsfp_decode (
  input  logic                      s1g_enable_i,
  input  logic [wsfp_pkg::SigW-1:0] sig_i,
  input  logic                      second_i,
  input  logic [wsfp_pkg::McsW-1:0] stored_mcs_i,
  output wsfp_pkg::dec_t            dec_o,
  output logic [wsfp_pkg::SymW-1:0] sym_o
);
  import wsfp_pkg::*;

  logic            perr;
  logic [NumW-1:0] num;
  div_t            div;
  logic [EncW-1:0] enc;
  logic            rate_ok;

  assign perr = (^sig_i[16:0]) != sig_i[17];

  always_comb begin
    rate_ok = 1'b1;
    unique case (sig_i[3:0])
      Rate6M:  enc = 3'd0;
      Rate9M:  enc = 3'd1;
      Rate12M: enc = 3'd2;
      Rate18M: enc = 3'd3;
      Rate24M: enc = 3'd4;
      Rate36M: enc = 3'd5;
      Rate48M: enc = 3'd6;
      Rate54M: enc = 3'd7;
      default: begin
        enc     = 3'd0;
        rate_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    dec_o            = '0;
    dec_o.status     = StatusOk;
    dec_o.modulation = ModBpsk;
    dec_o.mcs        = sig_i[22:19];
    num              = '0;
    div              = legacy_div(enc);
    if (s1g_enable_i && !second_i) begin
      dec_o.mcs_we = 1'b1;
      dec_o.status = StatusFirst;
    end else if (s1g_enable_i) begin
      dec_o.bytes = {{(LenW-S1gLenW){1'b0}}, sig_i[9:1]};
      num         = S1gOverhead + {{(NumW-S1gLenW-3){1'b0}}, sig_i[9:1], 3'b000};
      unique case (stored_mcs_i)
        Mcs0: begin
          dec_o.upd        = 1'b1;
          dec_o.enc        = 3'd0;
          dec_o.modulation = ModBpsk;
          div              = '{bias: 8'd25, shift: 3'd1, recip: 23'd322639};
        end
        Mcs1: begin
          dec_o.upd        = 1'b1;
          dec_o.enc        = 3'd2;
          dec_o.modulation = ModQpsk;
          div              = '{bias: 8'd51, shift: 3'd2, recip: 23'd322639};
        end
        Mcs2: begin
          dec_o.upd        = 1'b1;
          dec_o.enc        = 3'd3;
          dec_o.modulation = ModQpsk;
          div              = '{bias: 8'd77, shift: 3'd1, recip: 23'd107547};
        end
        default: dec_o.status = StatusRate;
      endcase
    end else begin
      dec_o.bytes = sig_i[16:5];
      num         = LegacyOverhead + {1'b0, sig_i[16:5], 3'b000};
      if (perr) begin
        dec_o.status = StatusParity;
      end else if (!rate_ok) begin
        dec_o.status = StatusRate;
      end else begin
        dec_o.upd        = 1'b1;
        dec_o.enc        = enc;
        dec_o.modulation = mod_e'(enc[2:1]);
      end
    end
  end

  wsfp_symdiv u_symdiv (
    .num_i (num),
    .div_i (div),
    .sym_o (sym_o)
  );

endmodule

### hw/rtl/wlan_signal_field_parser.sv
// A word taken into the input register is decoded and captured by the result register.
// Throughput: one word per cycle unless out_ready_i stalls; the input and result registers
//   keep both sides moving, and decode plus the reciprocal multiply fit between them.
// Reset (async, active low): both stages empty, legacy mode, held encoding,
//   symbol count, modulation (BPSK) and stored MCS cleared to zero.
module wlan_signal_field_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [wsfp_pkg::SigW-1:0] sig_bits_i,
  input  logic                      is_second_symbol_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [wsfp_pkg::EncW-1:0] encoding_o,
  output logic [wsfp_pkg::LenW-1:0] frame_bytes_o,
  output logic [wsfp_pkg::SymW-1:0] frame_symbols_o,
  output logic [1:0]                modulation_o
);
  import wsfp_pkg::*;

  logic            s1g_enable_q;
  logic            in_valid_q;
  logic [SigW-1:0] sig_q;
  logic            second_q;
  logic            out_valid_q;
  logic            adv;

  logic [McsW-1:0] stored_mcs_q;
  logic [EncW-1:0] held_enc_q;
  logic [SymW-1:0] held_sym_q;
  mod_e            held_mod_q;

  status_e         status_q;
  logic [EncW-1:0] enc_q;
  logic [LenW-1:0] bytes_q;
  logic [SymW-1:0] sym_q;
  mod_e            mod_q;

  dec_t            dec;
  logic [SymW-1:0] dec_sym;
  logic [EncW-1:0] enc_d;
  logic [SymW-1:0] sym_d;
  mod_e            mod_d;

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  wsfp_decode u_decode (
    .s1g_enable_i (s1g_enable_q),
    .sig_i        (sig_q),
    .second_i     (second_q),
    .stored_mcs_i (stored_mcs_q),
    .dec_o        (dec),
    .sym_o        (dec_sym)
  );

  assign enc_d = dec.upd ? dec.enc        : held_enc_q;
  assign sym_d = dec.upd ? dec_sym        : held_sym_q;
  assign mod_d = dec.upd ? dec.modulation : held_mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1g_enable_q <= 1'b0;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      stored_mcs_q <= '0;
      held_enc_q   <= '0;
      held_sym_q   <= '0;
      held_mod_q   <= ModBpsk;
    end else begin
      if (cfg_we_i) begin
        s1g_enable_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (adv) begin
        if (dec.mcs_we) begin
          stored_mcs_q <= dec.mcs;
        end
        held_enc_q <= enc_d;
        held_sym_q <= sym_d;
        held_mod_q <= mod_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sig_q    <= sig_bits_i;
      second_q <= is_second_symbol_i;
    end
    if (adv) begin
      status_q <= dec.status;
      enc_q    <= enc_d;
      bytes_q  <= dec.bytes;
      sym_q    <= sym_d;
      mod_q    <= mod_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign encoding_o      = enc_q;
  assign frame_bytes_o   = bytes_q;
  assign frame_symbols_o = sym_q;
  assign modulation_o    = mod_q;

  a_adv_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advanced word missing from result register");

  a_out_matches_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (enc_q == held_enc_q && sym_q == held_sym_q && mod_q == held_mod_q))
    else $error("reported settings differ from held settings");

  a_first_no_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == StatusFirst) |-> bytes_q == '0)
    else $error("first S1G symbol reports a length");

  a_stall_holds_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> (in_valid_q && $stable(sig_q) && $stable(second_q)))
    else $error("stalled input word lost");

  a_block_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input blocked while a stage is free");

endmodule
